### hdl/sts_pkg.sv
`default_nettype none

package sts_pkg;

  // longest atom text that the token port can carry
  localparam int unsigned NAME_MAX = 8;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // delimiter characters
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    KIND_END    = 3'd0,
    KIND_OPEN   = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_DOT    = 3'd3,
    KIND_QUOTE  = 3'd4,
    KIND_ATOM   = 3'd5,
    KIND_NUMBER = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ATOM = 2'd1,
    MODE_NUM  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] text;
    logic [3:0]  len;
    logic [31:0] num;
    logic        last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // ?!+-*/<=>:$%^&_~@
  function automatic logic is_sym(input logic [7:0] c);
    logic r;
    case (c)
      8'h3f, 8'h21, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3c, 8'h3d, 8'h3e,
      8'h3a, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h5f, 8'h7e, 8'h40: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/sexpr_token_scanner.sv
// s-expression token scanner
//
// input channel: one character per transaction (in_char), or an end mark
// (end_of_input = 1, in_char ignored). handshake is in_valid / in_stall.
// output channel: one token per transaction on token_kind, name_text,
// name_length, number_value and last_result, handshake out_valid / out_stall.
// an input causes zero, one or two tokens; last_result marks the final one.
//
// throughput: one character per cycle while in_stall is low. the character is
// classified and the scan state updated in the cycle it is accepted; its tokens
// are written to a four-entry result queue, whose head token drives the
// output from registers. in_stall rises while the queue holds three or more
// tokens, since a character may add two; that queue depth sets the rate when
// the receiver is slow.
//
// reset empties the queue and returns the scanner to idle with empty name
// and number registers. while out_stall is high the shown token holds and
// further characters are taken until in_stall rises.
`default_nettype none

module sexpr_token_scanner
  import sts_pkg::*;
#(
  parameter int unsigned NAME_LEN = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       token_kind,
  output logic [63:0]      name_text,
  output logic [3:0]       name_length,
  output logic [31:0]      number_value,
  output logic             last_result
);

  localparam int unsigned CW = $clog2(NAME_LEN + 1);

  // scan state
  mode_t       scan_mode, scan_mode_next;
  logic [7:0]  name_buffer [NAME_LEN];
  logic [7:0]  name_buffer_next [NAME_LEN];
  logic [CW-1:0] name_count, name_count_next;
  logic [31:0] number_accumulator, number_accumulator_next;

  // result queue
  token_t              queue [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] head, tail;
  logic [QUEUE_CW-1:0] count;

  logic       accept, pop;
  token_t     res0, res1, pend_tok, delim_tok;
  logic [1:0] res_n;
  logic       pend, has_delim, extend;
  logic [35:0] num_prod;
  logic [63:0] pend_text;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  // room for two tokens is needed before a character is taken
  assign in_stall  = count > QUEUE_CW'(QUEUE_DEPTH - 2);
  assign out_valid = count != '0;

  assign token_kind   = queue[head].kind;
  assign name_text    = queue[head].text;
  assign name_length  = queue[head].len;
  assign number_value = queue[head].num;
  assign last_result  = queue[head].last;

  // times ten plus digit, kept wide to catch overflow
  assign num_prod = {1'b0, number_accumulator, 3'b000}
                  + {3'b000, number_accumulator, 1'b0}
                  + {32'd0, in_char[3:0] - CH_ZERO[3:0]};

  // pending atom text, first character in the low byte
  always_comb begin
    pend_text = '0;
    for (int i = 0; i < NAME_LEN; i++) begin
      pend_text[8*i +: 8] = name_buffer[i];
    end
  end

  always_comb begin
    pend_tok = '0;
    pend     = 1'b0;
    case (scan_mode)
      MODE_ATOM: begin
        pend          = 1'b1;
        pend_tok.kind = KIND_ATOM;
        pend_tok.text = pend_text;
        pend_tok.len  = 4'(name_count);
      end
      MODE_NUM: begin
        pend          = 1'b1;
        pend_tok.kind = KIND_NUMBER;
        pend_tok.num  = number_accumulator;
      end
      default: pend = 1'b0;
    endcase
  end

  // delimiter token of the current character
  always_comb begin
    delim_tok      = '0;
    delim_tok.last = 1'b1;
    has_delim      = 1'b1;
    case (in_char)
      CH_OPEN:  delim_tok.kind = KIND_OPEN;
      CH_CLOSE: delim_tok.kind = KIND_CLOSE;
      CH_DOT:   delim_tok.kind = KIND_DOT;
      CH_QUOTE: delim_tok.kind = KIND_QUOTE;
      default:  has_delim = 1'b0;
    endcase
  end

  assign extend = (scan_mode == MODE_ATOM &&
                   (is_letter(in_char) || is_digit(in_char) || is_sym(in_char)))
               || (scan_mode == MODE_NUM && is_digit(in_char));

  always_comb begin
    scan_mode_next          = scan_mode;
    name_buffer_next        = name_buffer;
    name_count_next         = name_count;
    number_accumulator_next = number_accumulator;
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;

    if (end_of_input) begin
      // flush the pending token, then the end token
      scan_mode_next = MODE_IDLE;
      if (pend) begin
        res0       = pend_tok;
        res1       = '0;
        res1.kind  = KIND_END;
        res1.last  = 1'b1;
        res_n      = 2'd2;
      end else begin
        res0.kind = KIND_END;
        res0.last = 1'b1;
        res_n     = 2'd1;
      end
    end else if (extend) begin
      if (scan_mode == MODE_ATOM) begin
        // characters past the name limit are consumed and dropped
        for (int i = 0; i < NAME_LEN; i++) begin
          if (name_count == CW'(i)) begin
            name_buffer_next[i] = in_char;
          end
        end
        if (name_count < CW'(NAME_LEN)) begin
          name_count_next = name_count + 1'b1;
        end
      end else begin
        number_accumulator_next = (num_prod[35:32] != 4'd0) ? 32'hffff_ffff
                                                             : num_prod[31:0];
      end
    end else begin
      // close the pending token, then treat the character afresh
      scan_mode_next = MODE_IDLE;
      if (pend && has_delim) begin
        res0      = pend_tok;
        res1      = delim_tok;
        res_n     = 2'd2;
      end else if (pend) begin
        res0      = pend_tok;
        res0.last = 1'b1;
        res_n     = 2'd1;
      end else if (has_delim) begin
        res0  = delim_tok;
        res_n = 2'd1;
      end
      if (!has_delim) begin
        if (is_letter(in_char) || is_sym(in_char)) begin
          scan_mode_next = MODE_ATOM;
          for (int i = 0; i < NAME_LEN; i++) begin
            name_buffer_next[i] = '0;
          end
          name_buffer_next[0] = in_char;
          name_count_next     = CW'(1);
        end else if (is_digit(in_char)) begin
          scan_mode_next          = MODE_NUM;
          number_accumulator_next = {28'd0, in_char[3:0] - CH_ZERO[3:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode          <= MODE_IDLE;
      name_count         <= '0;
      number_accumulator <= '0;
      for (int i = 0; i < NAME_LEN; i++) begin
        name_buffer[i] <= '0;
      end
    end else if (accept) begin
      scan_mode          <= scan_mode_next;
      name_count         <= name_count_next;
      number_accumulator <= number_accumulator_next;
      name_buffer        <= name_buffer_next;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (accept && res_n != 2'd0) begin
      queue[tail] <= res0;
    end
    if (accept && res_n == 2'd2) begin
      queue[tail + 1'b1] <= res1;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      if (accept) begin
        tail <= tail + QUEUE_PW'(res_n);
      end
      count <= count + (accept ? QUEUE_CW'(res_n) : '0) - QUEUE_CW'(pop);
    end
  end

endmodule

`default_nettype wire

### hdl/sts_checker.sv
`default_nettype none

module sts_checker
  import sts_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        end_of_input,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  token_kind,
  input wire logic [63:0] name_text,
  input wire logic [3:0]  name_length,
  input wire logic [31:0] number_value,
  input wire logic        last_result
);

  // a stalled token stays shown
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("token dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(token_kind) && $stable(last_result)
                               && $stable(number_value) && $stable(name_text)
                               && $stable(name_length))
    else $error("token changed while stalled");

  // only a closed atom or number can be followed by another token of the same input
  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> token_kind == KIND_ATOM || token_kind == KIND_NUMBER)
    else $error("non-final token is not atom or number");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |-> last_result)
    else $error("end token not marked final");

  // an end mark always produces a token
  a_end_output: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_input |=> out_valid)
    else $error("end mark produced no token");

endmodule

bind sexpr_token_scanner sts_checker u_sts_checker (.*);

`default_nettype wire
